@@ rtl/core/sedge_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Shared widths, register indexes, reset values and luma coefficients.
// ----------------------------------------------------------------------------
package sedge_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } cfg_idx_t;

    // Register widths and reset values
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 16;
    localparam int THR_W   = 11;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;
    localparam logic [THR_W-1:0]   THR_RESET   = 11'd50;

    localparam int MIN_DIM = 3;

    // Pixel and luma datapath
    localparam int CHAN_W = 8;
    localparam int LUMA_W = 18;
    localparam logic [LUMA_W-1:0] COEF_R = 18'd299;
    localparam logic [LUMA_W-1:0] COEF_G = 18'd587;
    localparam logic [LUMA_W-1:0] COEF_B = 18'd114;

    // Gradient sums fit +/- 4 * 255000, squares and threshold square fit 42 bits
    localparam int GRAD_W  = 21;
    localparam int SQ_W    = 41;
    localparam int MAG_W   = 42;
    localparam int THRS_W  = 21;
    localparam logic [THRS_W-1:0] THR_SCALE = 21'd1000;

    // Result fields
    localparam int CX_W = 10;
    localparam int CY_W = 16;

endpackage

@@ rtl/core/sobel_edge_threshold_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge threshold unit
// Raster RGB to luma, two line stores in one block RAM, a 3x3 window and a
// squared-magnitude compare against the scaled threshold.
// ----------------------------------------------------------------------------
//
//  channel | handshake                      | payload
//  --------+--------------------------------+-----------------------------------
//  pixel   | pix_valid / pix_stall (out)    | red, green, blue
//  result  | res_valid (out) / res_stall    | edge_res, center_x, center_y,
//          |                                |   last_pixel
//  config  | cfg_valid / cfg_ready (out)    | cfg_index, cfg_data
//
//  A border pixel passes through accept and the line RAM read and write back;
//  an interior pixel adds gradient sums, squaring and compare, and then waits
//  while the result register is held by res_stall. pix_stall stays high until
//  the unit is back in idle, so a new pixel is taken only after the last one.
//  Reset clears counters and window and restores register defaults; the line
//  RAM is not cleared, and a result uses only entries written in the two rows
//  above it.
//  The result register holds its transaction while res_stall is high.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_unit #(
    parameter int MAX_WIDTH = sedge_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic [sedge_pkg::CHAN_W-1:0]     red,
    input  logic [sedge_pkg::CHAN_W-1:0]     green,
    input  logic [sedge_pkg::CHAN_W-1:0]     blue,

    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             edge_res,
    output logic [sedge_pkg::CX_W-1:0]       center_x,
    output logic [sedge_pkg::CY_W-1:0]       center_y,
    output logic                             last_pixel,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sedge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sedge_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sedge_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = ((CW > IMG_W_W) ? CW : IMG_W_W) + 1;
    localparam int XW   = (CW > CX_W) ? CW : CX_W;
    localparam int HW   = IMG_H_W + 1;
    localparam int RAMW = 2 * LUMA_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SQUARE = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;
    logic [THR_W-1:0]   thr_reg;

    // Raster position
    logic [CW-1:0]      col_reg, col_next;
    logic [IMG_H_W-1:0] row_reg, row_next;

    // Per-item capture
    logic [LUMA_W-1:0]  luma_reg;
    logic [CW-1:0]      addr_reg;
    logic               interior_reg;
    logic [CX_W-1:0]    cx_reg;
    logic [CY_W-1:0]    cy_reg;
    logic               last_reg;

    // Line RAM: {older, newer} luma per column
    logic [RAMW-1:0]    line_ram [MAX_WIDTH];
    logic [RAMW-1:0]    rd_data_reg;
    logic [LUMA_W-1:0]  up2, up1;

    logic [LUMA_W-1:0]  win_reg [3][3];

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [GRAD_W-1:0] gx_next, gy_next;
    logic [THRS_W-1:0]        thrs_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [MAG_W-1:0]         thr2_reg;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [2*THRS_W-1:0]      prod_t;
    logic [MAG_W-1:0]         mag2;

    logic               res_valid_reg;
    logic               edge_reg;
    logic [CX_W-1:0]    res_cx_reg;
    logic [CY_W-1:0]    res_cy_reg;
    logic               res_last_reg;

    logic               pix_take;
    logic               out_load;
    logic               ram_we;

    logic [EW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;
    logic               col_wrap, row_wrap;
    logic [XW-1:0]      cx_full;
    logic [LUMA_W-1:0]  luma;

    function automatic logic signed [GRAD_W-1:0] sx(input logic [LUMA_W-1:0] v);
        sx = $signed({{(GRAD_W-LUMA_W){1'b0}}, v});
    endfunction

    assign pix_stall = (state_reg != ST_IDLE);
    assign pix_take  = pix_valid && !pix_stall;
    assign cfg_ready = 1'b1;

    // Effective frame size: width clamped to [3, MAX_WIDTH], height to >= 3
    always_comb
    begin
        eff_w = EW'(img_w_reg);
        if (eff_w < EW'(MIN_DIM))
            eff_w = EW'(MIN_DIM);
        if (eff_w > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        eff_h = HW'(img_h_reg);
        if (eff_h < HW'(MIN_DIM))
            eff_h = HW'(MIN_DIM);
    end

    assign col_wrap = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign row_wrap = (HW'(row_reg) + HW'(1)) >= eff_h;
    assign cx_full  = XW'(col_reg) - XW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_take)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + IMG_H_W'(1);
            end
            else
            begin
                col_next = CW'(EW'(col_reg) + EW'(1));
            end
        end
    end

    assign luma = LUMA_W'(red) * COEF_R + LUMA_W'(green) * COEF_G
                + LUMA_W'(blue) * COEF_B;

    assign up2 = rd_data_reg[RAMW-1:LUMA_W];
    assign up1 = rd_data_reg[LUMA_W-1:0];

    // Sobel sums over the window after the new column shifts in
    assign gx_next = (sx(up2) - sx(win_reg[0][1]))
                   + ((sx(up1) - sx(win_reg[1][1])) <<< 1)
                   + (sx(luma_reg) - sx(win_reg[2][1]));
    assign gy_next = (sx(win_reg[2][1]) + (sx(win_reg[2][2]) <<< 1) + sx(luma_reg))
                   - (sx(win_reg[0][1]) + (sx(win_reg[0][2]) <<< 1) + sx(up2));

    assign prod_x = gx_reg * gx_reg;
    assign prod_y = gy_reg * gy_reg;
    assign prod_t = thrs_reg * thrs_reg;
    assign mag2   = MAG_W'(sqx_reg) + MAG_W'(sqy_reg);

    assign ram_we   = (state_reg == ST_READ);
    assign out_load = (state_reg == ST_DECIDE) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (pix_take)
                    state_next = ST_READ;
            ST_READ:
                state_next = interior_reg ? ST_SQUARE : ST_IDLE;
            ST_SQUARE:
                state_next = ST_DECIDE;
            ST_DECIDE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            img_w_reg     <= IMG_W_RESET;
            img_h_reg     <= IMG_H_RESET;
            thr_reg       <= THR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_IMAGE_WIDTH:    img_w_reg <= cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT:   img_h_reg <= cfg_data[IMG_H_W-1:0];
                    REG_EDGE_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // Shift the window left and insert the new column
            if (state_reg == ST_READ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up2;
                win_reg[1][2] <= up1;
                win_reg[2][2] <= luma_reg;
            end

            if (out_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            luma_reg     <= luma;
            addr_reg     <= col_reg;
            interior_reg <= (col_reg >= CW'(2)) && (row_reg >= IMG_H_W'(2));
            cx_reg       <= cx_full[CX_W-1:0];
            cy_reg       <= row_reg - IMG_H_W'(1);
            last_reg     <= col_wrap && row_wrap;
        end
        if (state_reg == ST_READ)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            thrs_reg <= THRS_W'(thr_reg) * THR_SCALE;
        end
        if (state_reg == ST_SQUARE)
        begin
            sqx_reg  <= prod_x[SQ_W-1:0];
            sqy_reg  <= prod_y[SQ_W-1:0];
            thr2_reg <= prod_t[MAG_W-1:0];
        end
        if (out_load)
        begin
            edge_reg     <= (mag2 > thr2_reg);
            res_cx_reg   <= cx_reg;
            res_cy_reg   <= cy_reg;
            res_last_reg <= last_reg;
        end
    end

    // Line RAM: read at accept, move the column up one row on write back
    always_ff @(posedge clk)
    begin
        if (ram_we)
            line_ram[addr_reg] <= {up1, luma_reg};
        if (pix_take)
            rd_data_reg <= line_ram[col_reg];
    end

    assign res_valid  = res_valid_reg;
    assign edge_res   = edge_reg;
    assign center_x   = res_cx_reg;
    assign center_y   = res_cy_reg;
    assign last_pixel = res_last_reg;

`ifndef SYNTHESIS
    a_take_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        pix_take |=> state_reg == ST_READ)
        else $error("accepted pixel did not start a line RAM read");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(pix_take))
        else $error("line RAM write without a preceding read");

    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result raised outside the decide step");

    a_decide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) && res_valid_reg && res_stall |=> state_reg == ST_DECIDE)
        else $error("decide step dropped a pending result");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) < EW'(MAX_WIDTH))
        else $error("column counter beyond line RAM depth");
`endif

endmodule
